// ----- sv/cwsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwsd_pkg
// Shared constants, register codes and types for the chained word-stream
// decryptor.
// ----------------------------------------------------------------------------
package cwsd_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned AddrW = 4;

    localparam logic [WordW-1:0] RESET_SEED_KEY       = 32'h63DA901F;
    localparam logic [WordW-1:0] RESET_ADD_KEY        = 32'h63DA901F;
    localparam logic [WordW-1:0] RESET_XOR_KEY        = 32'h480C9A12;
    localparam logic [WordW-1:0] RESET_MUL_OFFSET_KEY = 32'h5AE007DF;

    typedef enum logic [1:0] {
        REG_SEED_KEY       = 2'd0,
        REG_ADD_KEY        = 2'd1,
        REG_XOR_KEY        = 2'd2,
        REG_MUL_OFFSET_KEY = 2'd3
    } cwsd_reg_idx_t;

    typedef struct packed {
        logic [WordW-1:0] seed_key;
        logic [WordW-1:0] add_key;
        logic [WordW-1:0] xor_key;
        logic [WordW-1:0] mul_offset_key;
    } cwsd_cfg_t;

endpackage

// ----- sv/chained_word_stream_decrypt_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_word_stream_decrypt_top
// Decrypts a stream of 32-bit words with a running sum key, a chaining key
// and a word index that restart at each end-of-section mark.
//
// Channel   Direction  Handshake                 Payload
// input     in         in_valid / in_stall       cipher_word, end_of_section
// output    out        out_valid / out_stall     plain_word
// config    in         psel/penable/pwrite       paddr, pwdata, prdata
//
// One request per cycle sustained while the output is not stalled; the input
// stage and the result register lie between accept and result. Key state
// advances at accept (one add and xor); the index multiply sits in the logic
// between the input stage and the result register. Reset loads the key
// registers with their reset values and the section state with the seed and
// index zero. A stalled result holds; one more request is taken into the
// input stage while it waits.
module chained_word_stream_decrypt_top
    import cwsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [WordW-1:0] cipher_word,
    input  logic             end_of_section,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [WordW-1:0] plain_word,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [WordW-1:0] pwdata,
    output logic [WordW-1:0] prdata,
    output logic             pready
);

    cwsd_cfg_t        cfg;

    logic [WordW-1:0] sum_reg,   sum_next;
    logic [WordW-1:0] chain_reg, chain_next;
    logic [WordW-1:0] index_reg, index_next;

    logic             s1_valid_reg, s1_valid_next;
    logic [WordW-1:0] s1_cx_reg;
    logic [WordW-1:0] s1_cpo_reg;
    logic [WordW-1:0] s1_idx_reg;

    logic             out_valid_reg, out_valid_next;
    logic [WordW-1:0] plain_reg;

    logic [WordW-1:0] w;
    logic [WordW-1:0] mix;
    logic             accept;
    logic             out_load;

    cwsd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign w        = ~cipher_word;
    assign out_load = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !out_load;
    assign accept   = in_valid && !in_stall;
    assign mix      = s1_idx_reg * s1_cpo_reg;

    assign out_valid  = out_valid_reg;
    assign plain_word = plain_reg;

    // advance section state per request
    always_comb
    begin
        sum_next   = sum_reg;
        chain_next = chain_reg;
        index_next = index_reg;
        if (accept)
        begin
            if (end_of_section)
            begin
                sum_next   = cfg.seed_key;
                chain_next = cfg.seed_key;
                index_next = '0;
            end
            else
            begin
                sum_next   = sum_reg + (w ^ cfg.xor_key);
                chain_next = (sum_reg + cfg.add_key) ^ w;
                index_next = index_reg + WordW'(1);
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (out_load)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= RESET_SEED_KEY;
            chain_reg     <= RESET_SEED_KEY;
            index_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            chain_reg     <= chain_next;
            index_reg     <= index_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cx_reg  <= chain_reg ^ w;
            s1_cpo_reg <= chain_reg + cfg.mul_offset_key;
            s1_idx_reg <= index_reg;
        end
        if (out_load)
            plain_reg <= s1_cx_reg ^ mix;
    end

`ifndef NO_ASSERTIONS
    a_eos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_section) |=> (index_reg == '0 && sum_reg == chain_reg))
        else $error("section state not restarted after end of section");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !end_of_section) |=> (index_reg == $past(index_reg) + WordW'(1)))
        else $error("word index did not advance");

    a_index_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(index_reg))
        else $error("word index changed without a request");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");
`endif

endmodule

// ----- sv/cwsd_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwsd_regs
// APB-style register file holding the four key registers.
// ----------------------------------------------------------------------------
module cwsd_regs
    import cwsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [WordW-1:0] pwdata,
    output logic [WordW-1:0] prdata,
    output logic             pready,
    output cwsd_cfg_t        cfg
);

    cwsd_cfg_t     cfg_reg;
    cwsd_cfg_t     cfg_next;
    cwsd_reg_idx_t reg_idx;
    logic          wr_en;

    assign reg_idx = cwsd_reg_idx_t'(paddr[AddrW-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_SEED_KEY:       cfg_next.seed_key       = pwdata;
                REG_ADD_KEY:        cfg_next.add_key        = pwdata;
                REG_XOR_KEY:        cfg_next.xor_key        = pwdata;
                REG_MUL_OFFSET_KEY: cfg_next.mul_offset_key = pwdata;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SEED_KEY:       prdata = cfg_reg.seed_key;
            REG_ADD_KEY:        prdata = cfg_reg.add_key;
            REG_XOR_KEY:        prdata = cfg_reg.xor_key;
            REG_MUL_OFFSET_KEY: prdata = cfg_reg.mul_offset_key;
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seed_key       <= RESET_SEED_KEY;
            cfg_reg.add_key        <= RESET_ADD_KEY;
            cfg_reg.xor_key        <= RESET_XOR_KEY;
            cfg_reg.mul_offset_key <= RESET_MUL_OFFSET_KEY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- verif/cwsd_plain_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwsd_plain_checker
// Watches the cipher, plain and register channels of the chained word-stream
// decryptor. Each accepted request updates a local copy of the section
// state and queues the plain word that the block must return.
// Each returned word is compared with the oldest queued one, and register
// reads are compared with the local copy of the keys.
// ----------------------------------------------------------------------------
module cwsd_plain_checker
    import cwsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic [WordW-1:0] cipher_word,
    input  logic             end_of_section,
    input  logic             out_valid,
    input  logic             out_stall,
    input  logic [WordW-1:0] plain_word,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [WordW-1:0] pwdata,
    input  logic [WordW-1:0] prdata,
    input  logic             pready,
    output int               mismatch_count,
    output int               words_in_flight
);

    cwsd_cfg_t        key_cfg;
    logic [WordW-1:0] sum_key;
    logic [WordW-1:0] chain_key;
    logic [WordW-1:0] word_idx;
    logic [WordW-1:0] plain_expected[$];

    // Sample mid-cycle: everything is stable until the next rising edge.
    always @(negedge clk or negedge rst_n)
    begin : watch
        logic [WordW-1:0] inv_word;
        logic [WordW-1:0] next_chain;
        logic [WordW-1:0] exp_word;
        logic [WordW-1:0] reg_value;
        cwsd_reg_idx_t    reg_idx;
        if (!rst_n)
        begin
            key_cfg.seed_key       = RESET_SEED_KEY;
            key_cfg.add_key        = RESET_ADD_KEY;
            key_cfg.xor_key        = RESET_XOR_KEY;
            key_cfg.mul_offset_key = RESET_MUL_OFFSET_KEY;
            sum_key                = RESET_SEED_KEY;
            chain_key              = RESET_SEED_KEY;
            word_idx               = '0;
            mismatch_count         = 0;
            plain_expected.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (plain_expected.size() == 0)
                begin
                    $display("%0t unexpected plain_word: expected none, actual %h",
                             $time, plain_word);
                    mismatch_count++;
                end
                else
                begin
                    exp_word = plain_expected.pop_front();
                    if (plain_word !== exp_word)
                    begin
                        $display("%0t plain_word mismatch: expected %h, actual %h",
                                 $time, exp_word, plain_word);
                        mismatch_count++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                inv_word   = ~cipher_word;
                next_chain = (sum_key + key_cfg.add_key) ^ inv_word;
                plain_expected.push_back((chain_key ^ inv_word) ^
                                         (word_idx * (chain_key + key_cfg.mul_offset_key)));
                sum_key    = sum_key + (inv_word ^ key_cfg.xor_key);
                chain_key  = next_chain;
                word_idx   = word_idx + WordW'(1);
                if (end_of_section)
                begin
                    sum_key   = key_cfg.seed_key;
                    chain_key = key_cfg.seed_key;
                    word_idx  = '0;
                end
            end

            if (psel && penable && pready)
            begin
                reg_idx = cwsd_reg_idx_t'(paddr[AddrW-1:2]);
                case (reg_idx)
                    REG_SEED_KEY:       reg_value = key_cfg.seed_key;
                    REG_ADD_KEY:        reg_value = key_cfg.add_key;
                    REG_XOR_KEY:        reg_value = key_cfg.xor_key;
                    default:            reg_value = key_cfg.mul_offset_key;
                endcase
                if (pwrite)
                begin
                    case (reg_idx)
                        REG_SEED_KEY:       key_cfg.seed_key       = pwdata;
                        REG_ADD_KEY:        key_cfg.add_key        = pwdata;
                        REG_XOR_KEY:        key_cfg.xor_key        = pwdata;
                        default:            key_cfg.mul_offset_key = pwdata;
                    endcase
                end
                else if (prdata !== reg_value)
                begin
                    $display("%0t prdata mismatch at %h: expected %h, actual %h",
                             $time, paddr, reg_value, prdata);
                    mismatch_count++;
                end
            end
        end
        words_in_flight = plain_expected.size();
    end

endmodule

// ----- verif/tb_chained_word_stream_decrypt_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chained_word_stream_decrypt_top
// Drives cipher words and register accesses into the chained word-stream
// decryptor: a directed opening over word extremes, all-zero and all-one keys
// and a seed change inside a section, then random phases of sections with
// random keys, random idling on both channels and one phase without it.
// The checker beside the block predicts and compares; this module gives
// the verdict.
// ----------------------------------------------------------------------------
module tb_chained_word_stream_decrypt_top;
    import cwsd_pkg::*;

    localparam int unsigned CycleLimit   = 200000;
    localparam int unsigned SettleCycles = 4;
    localparam int unsigned PhaseCount   = 8;
    localparam int unsigned PhaseItems   = 235;

    logic             clk            = 1'b0;
    logic             rst_n          = 1'b0;
    logic             in_valid       = 1'b0;
    logic [WordW-1:0] cipher_word    = '0;
    logic             end_of_section = 1'b0;
    logic             out_stall      = 1'b0;
    logic             psel           = 1'b0;
    logic             penable        = 1'b0;
    logic             pwrite         = 1'b0;
    logic [AddrW-1:0] paddr          = '0;
    logic [WordW-1:0] pwdata         = '0;
    logic             in_stall;
    logic             out_valid;
    logic [WordW-1:0] plain_word;
    logic [WordW-1:0] prdata;
    logic             pready;
    int               mismatch_count;
    int               words_in_flight;
    int unsigned      cycles         = 0;
    logic             calm           = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    chained_word_stream_decrypt_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cipher_word    (cipher_word),
        .end_of_section (end_of_section),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .plain_word     (plain_word),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    cwsd_plain_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cipher_word     (cipher_word),
        .end_of_section  (end_of_section),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .plain_word      (plain_word),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .words_in_flight (words_in_flight)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit)
        begin
            $display("chained_word_stream_decrypt_top test failed");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 14);

    task automatic send_word(input logic [WordW-1:0] word, input logic last);
        logic taken;
        if (!calm)
        begin
            while ($urandom_range(99) < 14)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid       <= 1'b1;
        cipher_word    <= word;
        end_of_section <= last;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (words_in_flight != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic apb_access(input cwsd_reg_idx_t idx, input logic wr,
                              input logic [WordW-1:0] data);
        logic done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            done = pready;
            @(posedge clk);
        end
        while (!done);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_keys(input cwsd_cfg_t keys);
        apb_access(REG_SEED_KEY, 1'b1, keys.seed_key);
        apb_access(REG_ADD_KEY, 1'b1, keys.add_key);
        apb_access(REG_XOR_KEY, 1'b1, keys.xor_key);
        apb_access(REG_MUL_OFFSET_KEY, 1'b1, keys.mul_offset_key);
        apb_access(REG_SEED_KEY, 1'b0, '0);
        apb_access(REG_ADD_KEY, 1'b0, '0);
        apb_access(REG_XOR_KEY, 1'b0, '0);
        apb_access(REG_MUL_OFFSET_KEY, 1'b0, '0);
    endtask

    function automatic logic [WordW-1:0] pick_key();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_sections(input int unsigned count, input int unsigned pause_at);
        int unsigned sent;
        int unsigned len;
        int unsigned mode;
        int unsigned k;
        logic        last;
        logic        paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < count)
        begin
            mode = $urandom_range(9);
            len  = (mode == 0) ? $urandom_range(300, 100) : $urandom_range(40, 1);
            for (k = 0; k < len && sent < count; k++)
            begin
                // mostly one mark at the end; the rest marks at random
                if (mode == 9)
                    last = ($urandom_range(2) == 0);
                else
                    last = (k == len - 1);
                send_word($urandom, last);
                sent++;
                if (!paused && sent >= pause_at)
                begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end
    endtask

    initial
    begin
        int unsigned ph;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b1);
        send_word(32'h5555_5555, 1'b1);
        drain_results();

        load_keys('0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h1234_5678, 1'b1);
        drain_results();

        load_keys('1);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b1);
        drain_results();

        // change the seed inside a section; it applies after the next mark
        send_word(32'hDEAD_BEEF, 1'b0);
        send_word(32'h0F0F_0F0F, 1'b0);
        drain_results();
        apb_access(REG_SEED_KEY, 1'b1, 32'h0BAD_F00D);
        send_word(32'hF0F0_F0F0, 1'b0);
        send_word(32'hC001_D00D, 1'b1);
        send_word(32'h1357_9BDF, 1'b0);
        send_word(32'h2468_ACE0, 1'b1);
        drain_results();

        for (ph = 0; ph < PhaseCount; ph++)
        begin
            load_keys({pick_key(), pick_key(), pick_key(), pick_key()});
            calm <= (ph == 5);
            run_sections(PhaseItems, (ph == 3) ? PhaseItems / 2 : PhaseItems + 1);
            drain_results();
        end
        calm <= 1'b0;

        if (mismatch_count == 0 && words_in_flight == 0)
            $display("chained_word_stream_decrypt_top test passed");
        else
            $display("chained_word_stream_decrypt_top test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/cwsd_pkg.sv
sv/cwsd_regs.sv
sv/chained_word_stream_decrypt_top.sv
verif/cwsd_plain_checker.sv
verif/tb_chained_word_stream_decrypt_top.sv
